// ===== rtl/dtf_pkg.sv =====
// Shared types and constants for the decimal text to fixed point parser.
// No dependencies; imported by dtf_frac_div, decimal_text_to_fixed_point_core and the testbench.
`default_nettype none

package dtf_pkg;

  localparam int CHAR_W  = 8;
  localparam int FDIG_W  = 30;   // kept fraction digits, below 10^9
  localparam int FCNT_W  = 4;    // number of kept fraction digits
  localparam int CNT_W   = 16;   // consumed character count
  localparam int VALUE_W = 48;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // 10^n for n = 0..9
  localparam logic [FDIG_W-1:0] POW10 [0:9] = '{
    30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
    30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
  };

  typedef enum logic [3:0] {
    PH_BLANK = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/dtf_frac_div.sv =====
// Iterative restoring divider for the fraction: quotient of
// (dividend << FRAC_BITS) / divisor, one quotient bit per cycle. Uses dtf_pkg.
`default_nettype none

module dtf_frac_div
  import dtf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [FDIG_W-1:0]    dividend,   // must be below divisor
  input  wire logic [FDIG_W-1:0]    divisor,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quotient
);

  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic [FDIG_W:0]        rem_r, rem_nxt;
  logic [FDIG_W-1:0]      div_r, div_nxt;
  logic [FRAC_BITS-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic [FDIG_W:0]        rem_sh;
  logic [FDIG_W+1:0]      diff;

  // remainder stays below divisor, so doubling fits in FDIG_W+1 bits
  assign rem_sh = {rem_r[FDIG_W-1:0], 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend};
      div_nxt  = divisor;
      q_nxt    = '0;
      step_nxt = STEP_W'(FRAC_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[FDIG_W+1]) begin
        rem_nxt = diff[FDIG_W:0];
        q_nxt   = {q_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[FRAC_BITS-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point_core.sv =====
// Streaming decimal text parser: one character per transaction in, one
// signed fixed-point result per parsed number out. Uses dtf_pkg, dtf_frac_div.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | [7:0] char_code                | first
//  out_    | out | [47:0] value, [63:48] consumed | overflow
//
// A character that does not end the number is taken in S_IDLE, which stays ready.
// The ending character starts the fraction divider, one quotient bit per cycle;
// the core then moves through S_DIV and S_EMIT before it returns to S_IDLE.
// in_tready is low while the divider runs and while a result waits for a
// free output register; a held result does not block plain characters.
// Synchronous active-low reset leaves the parser as if a start had been seen.
`default_nettype none

module decimal_text_to_fixed_point_core
  import dtf_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int INT_BITS        = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tuser,   // [0] first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [47:0] value, [63:48] consumed
  output logic             out_tuser   // [0] overflow
);

  localparam int PROD_W = INT_BITS + 4;
  localparam int MAG_W  = INT_BITS + FRAC_BITS;
  localparam logic [INT_BITS-1:0] INT_MAX = '1;

  seq_state_t              state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic                    neg_r, neg_nxt;
  logic [INT_BITS-1:0]     acc_r, acc_nxt;
  logic [FDIG_W-1:0]       fdig_r, fdig_nxt;
  logic [FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [63:0]             out_data_r, out_data_nxt;
  logic                    out_user_r, out_user_nxt;

  // effective state after an optional start
  phase_t                  ph_cur, ph_mid;
  logic                    neg_cur;
  logic [INT_BITS-1:0]     acc_cur;
  logic [FDIG_W-1:0]       fdig_cur;
  logic [FCNT_W-1:0]       fcnt_cur;
  logic [CNT_W-1:0]        cnt_cur, cnt_inc;
  logic                    ovf_cur;

  logic [CHAR_W-1:0]       ch;
  logic [3:0]              digit;
  logic                    is_digit, is_blank, is_sign;
  logic [PROD_W-1:0]       prod;
  logic                    accept;
  logic                    div_start, div_done;
  logic [FRAC_BITS-1:0]    frac_q;
  logic [MAG_W-1:0]        mag_full;
  logic [VALUE_W-1:0]      mag, value;
  logic                    out_free;

  assign accept   = in_tvalid && in_tready;
  assign ch       = in_tdata;
  assign digit    = 4'(ch - CH_ZERO);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

  assign ph_cur   = in_tuser ? PH_BLANK : phase_r;
  assign neg_cur  = in_tuser ? 1'b0 : neg_r;
  assign acc_cur  = in_tuser ? '0 : acc_r;
  assign fdig_cur = in_tuser ? '0 : fdig_r;
  assign fcnt_cur = in_tuser ? '0 : fcnt_r;
  assign cnt_cur  = in_tuser ? '0 : cnt_r;
  assign ovf_cur  = in_tuser ? 1'b0 : ovf_r;
  assign cnt_inc  = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign ph_mid   = (ph_cur == PH_BLANK) ? PH_INT : ph_cur;

  // acc * 10 + digit; above INT_MAX means saturation
  assign prod = {acc_cur, 3'b000} + {2'b00, acc_cur, 1'b0} + PROD_W'(digit);

  assign out_free = !out_valid_r || out_tready;
  assign mag_full = {acc_r, frac_q};
  assign mag      = VALUE_W'(mag_full);
  assign value    = neg_r ? (~mag + 1'b1) : mag;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    fdig_nxt      = fdig_r;
    fcnt_nxt      = fcnt_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    case (state_r)
      S_IDLE: begin
        if (accept && ph_cur != PH_DONE) begin
          phase_nxt = ph_cur;
          neg_nxt   = neg_cur;
          acc_nxt   = acc_cur;
          fdig_nxt  = fdig_cur;
          fcnt_nxt  = fcnt_cur;
          cnt_nxt   = cnt_cur;
          ovf_nxt   = ovf_cur;
          if (ph_cur == PH_BLANK && is_blank) begin
            cnt_nxt = cnt_inc;
          end else if (ph_cur == PH_BLANK && is_sign) begin
            neg_nxt   = (ch == CH_MINUS);
            phase_nxt = PH_INT;
            cnt_nxt   = cnt_inc;
          end else if (ch == CH_POINT && ph_mid == PH_INT) begin
            phase_nxt = PH_FRAC;
            cnt_nxt   = cnt_inc;
          end else if (!is_digit) begin
            // end of number: scale the fraction digits
            phase_nxt = PH_DONE;
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else if (ph_mid == PH_INT) begin
            phase_nxt = PH_INT;
            cnt_nxt   = cnt_inc;
            if (prod > PROD_W'(INT_MAX)) begin
              acc_nxt = INT_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = prod[INT_BITS-1:0];
            end
          end else begin
            cnt_nxt = cnt_inc;
            if (fcnt_cur < FCNT_W'(MAX_FRAC_DIGITS)) begin
              fdig_nxt = {fdig_cur[FDIG_W-4:0], 3'b000} + {fdig_cur[FDIG_W-2:0], 1'b0}
                         + FDIG_W'(digit);
              fcnt_nxt = fcnt_cur + 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {cnt_r, value};
          out_user_nxt  = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BLANK;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      fdig_r      <= '0;
      fcnt_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      fdig_r      <= fdig_nxt;
      fcnt_r      <= fcnt_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // fcnt_nxt never exceeds MAX_FRAC_DIGITS, so the table index stays in range
  dtf_frac_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_frac_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (fdig_nxt),
    .divisor  (POW10[fcnt_nxt]),
    .done     (div_done),
    .quotient (frac_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for decimal_text_to_fixed_point_core: streams characters in,
// predicts numbers by a local parser model or typed rows and checks every result.
// Depends on rtl/dtf_pkg.sv and rtl/decimal_text_to_fixed_point_core.sv.
module testbench
  import dtf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int INT_BITS        = 31;
  localparam longint unsigned INT_MAX = (64'd1 << INT_BITS) - 1;
  localparam int RANDOM_CHARS    = 1050;

  typedef struct packed {
    logic [47:0] value;
    logic [15:0] consumed;
    logic        ovf;
  } number_t;

  typedef struct {
    string       text;
    bit          lead_first;
    bit          has_term;
    logic [7:0]  term;
    bit          has_want;
    number_t     want;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_code
  logic        in_tuser   = 1'b0; // [0] first
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [47:0] value, [63:48] consumed
  logic        out_tuser;         // [0] overflow

  decimal_text_to_fixed_point_core #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
    .INT_BITS       (INT_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #600_000;
    $display("TEST FAILED");
    $finish;
  end

  // parser model state
  phase_t          prs_phase;
  bit              prs_neg;
  longint unsigned prs_int;
  int unsigned     prs_frac;
  int unsigned     prs_fcnt;
  logic [15:0]     prs_cnt;
  bit              prs_ovf;

  number_t    pending_numbers[$];
  logic [7:0] text_q[$];
  dir_row_t   dir_rows[$];
  int         mismatches = 0;
  int         chars_sent = 0;
  bit         idling_on = 1'b1;
  bit         hold_off_req = 1'b0;
  bit         hold_off_done = 1'b0;
  int         sink_wait = 0;

  function automatic void clear_parser();
    prs_phase = PH_BLANK;
    prs_neg   = 1'b0;
    prs_int   = 0;
    prs_frac  = 0;
    prs_fcnt  = 0;
    prs_cnt   = '0;
    prs_ovf   = 1'b0;
  endfunction

  function automatic void count_char();
    if (prs_cnt != CNT_MAX) prs_cnt++;
  endfunction

  // Advances the parser model by one character; returns 1 when it ends a number.
  function automatic bit parse_char(input logic [7:0] c, input logic f, output number_t res);
    longint unsigned d, frac, mag, scale;
    res = '0;
    if (f) clear_parser();
    if (prs_phase == PH_DONE) return 1'b0;
    if (prs_phase == PH_BLANK) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        count_char();
        return 1'b0;
      end
      if (c == CH_PLUS || c == CH_MINUS) begin
        prs_neg   = (c == CH_MINUS);
        prs_phase = PH_INT;
        count_char();
        return 1'b0;
      end
      prs_phase = PH_INT;
    end
    if (c == CH_POINT && prs_phase == PH_INT) begin
      prs_phase = PH_FRAC;
      count_char();
      return 1'b0;
    end
    if (c < CH_ZERO || c > CH_NINE) begin
      scale = 1;
      for (int i = 0; i < prs_fcnt; i++) scale = scale * 10;
      frac = (longint'(prs_frac) << FRAC_BITS) / scale;
      mag  = (prs_int << FRAC_BITS) + frac;
      if (prs_neg) mag = 64'd0 - mag;
      res.value    = mag[47:0];
      res.consumed = prs_cnt;
      res.ovf      = prs_ovf;
      prs_phase    = PH_DONE;
      return 1'b1;
    end
    d = 64'(c - CH_ZERO);
    if (prs_phase == PH_INT) begin
      if (prs_int > (INT_MAX - d) / 10) begin
        prs_int = INT_MAX;
        prs_ovf = 1'b1;
      end else begin
        prs_int = prs_int * 10 + d;
      end
    end else if (prs_fcnt < MAX_FRAC_DIGITS) begin
      prs_frac = 32'(prs_frac * 10 + d);
      prs_fcnt++;
    end
    count_char();
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Offers one character, waits for the transaction, then records what it should produce.
  task automatic send_char(input logic [7:0] c, input logic f,
                           input bit use_typed, input number_t typed);
    logic    took;
    number_t res;
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= f;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    chars_sent++;
    if (parse_char(c, f, res)) pending_numbers.push_back(use_typed ? typed : res);
  endtask

  task automatic send_text(input bit noisy);
    foreach (text_q[i])
      send_char(text_q[i], i == 0 || (noisy && $urandom_range(0, 3) == 0), 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_digit();
    logic [7:0] c;
    c = 8'(CH_ZERO + $urandom_range(0, 9));
    return c;
  endfunction

  // any byte that ends a number once digits have started
  function automatic logic [7:0] pick_stop();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'd0;
    do c = 8'($urandom_range(0, 255)); while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT);
    return c;
  endfunction

  // blanks, sign, integer digits and an optional fraction, no terminator
  task automatic build_number();
    int n;
    text_q.delete();
    n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(0, 2))
      1: text_q.push_back(CH_PLUS);
      2: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(10, 12)) text_q.push_back(CH_NINE);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
      repeat (n) text_q.push_back(pick_digit());
    end
    if ($urandom_range(0, 1) == 1) begin
      text_q.push_back(CH_POINT);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
      repeat (n) text_q.push_back(pick_digit());
    end
  endtask

  function automatic void add_row(input string text, input bit lead_first,
                                  input bit has_term, input logic [7:0] term,
                                  input bit has_want, input logic [47:0] w_value,
                                  input logic [15:0] w_consumed, input logic w_ovf);
    dir_row_t r;
    r.text          = text;
    r.lead_first    = lead_first;
    r.has_term      = has_term;
    r.term          = term;
    r.has_want      = has_want;
    r.want.value    = w_value;
    r.want.consumed = w_consumed;
    r.want.ovf      = w_ovf;
    dir_rows.push_back(r);
  endfunction

  // result sink: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (sink_wait != 0) begin
      sink_wait  <= sink_wait - 1;
      out_tready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      sink_wait     <= 599;
      out_tready    <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      sink_wait  <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // nothing changes between the falling edge and the next rising one,
  // so a handshake seen here is the transaction at that rising edge
  always @(negedge clk) begin : result_check
    number_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value    = out_tdata[47:0];
      got.consumed = out_tdata[63:48];
      got.ovf      = out_tuser;
      if (pending_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h consumed=%0d",
                                  got.value, got.consumed));
      end else begin
        want = pending_numbers.pop_front();
        if (got.value !== want.value)
          report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
        if (got.consumed !== want.consumed)
          report_mismatch($sformatf("consumed %0d, expected %0d", got.consumed, want.consumed));
        if (got.ovf !== want.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", got.ovf, want.ovf));
      end
    end
  end

  initial begin : stimulus
    int         kind;
    bit         noisy;
    bit         hold_armed;
    logic [7:0] ch;
    dir_row_t   row;

    clear_parser();
    hold_armed = 1'b0;

    //       text                first  term?  term   typed? value               cnt  ovf
    add_row("7",                 0,     1,     8'd0,  1,     48'h0000_0007_0000, 1,   0);
    add_row("",                  1,     1,     8'd0,  1,     48'h0,              0,   0);
    add_row(" \t-",              1,     1,     8'd0,  1,     48'h0,              3,   0);
    add_row(".",                 1,     1,     8'd0,  1,     48'h0,              1,   0);
    add_row("+",                 1,     1,     "-",   1,     48'h0,              1,   0);
    add_row("-",                 1,     1,     " ",   1,     48'h0,              1,   0);
    add_row("1.2",               1,     1,     ".",   0,     48'h0,              0,   0);
    add_row("-0.0",              1,     1,     8'd0,  1,     48'h0,              4,   0);
    add_row("99999999999",       1,     1,     8'd0,  1,     48'h7FFF_FFFF_0000, 11,  1);
    add_row("-99999999999",      1,     1,     8'd0,  1,     48'h8000_0001_0000, 12,  1);
    add_row("-2147483647.999999999999", 1, 1,  8'd0,  0,     48'h0,              0,   0);
    add_row("0.123456789123",    1,     1,     "x",   0,     48'h0,              0,   0);
    add_row("5",                 1,     1,     ":",   1,     48'h0000_0005_0000, 1,   0);
    add_row("77",                0,     0,     8'd0,  0,     48'h0,              0,   0);
    add_row("3",                 1,     1,     "/",   1,     48'h0000_0003_0000, 1,   0);
    add_row("123",               1,     0,     8'd0,  0,     48'h0,              0,   0);
    add_row("4",                 1,     1,     8'hFF, 1,     48'h0000_0004_0000, 1,   0);
    add_row("0",                 1,     1,     8'h80, 1,     48'h0,              1,   0);
    add_row("\t+00001.5",        1,     1,     8'd0,  0,     48'h0,              0,   0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int i = 0; i < row.text.len(); i++) begin
        ch = row.text[i];
        send_char(ch, row.lead_first && i == 0, row.has_want, row.want);
      end
      if (row.has_term)
        send_char(row.term, row.lead_first && row.text.len() == 0, row.has_want, row.want);
    end

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (!hold_armed && chars_sent >= 300) begin
        hold_armed = 1'b1;
        hold_off_req <= 1'b1;
      end
      if ($urandom_range(0, 24) == 0) idling_on <= !idling_on;
      kind  = $urandom_range(0, 15);
      noisy = 1'b0;
      build_number();
      if (kind < 11) begin
        text_q.push_back(pick_stop());
      end else if (kind < 13) begin
        // malformed: a sign, point, blank or random byte put in at a random place
        case ($urandom_range(0, 3))
          0: ch = CH_MINUS;
          1: ch = CH_POINT;
          2: ch = CH_SPACE;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        if (text_q.size() == 0) text_q.push_back(ch);
        else text_q[$urandom_range(0, text_q.size() - 1)] = ch;
        text_q.push_back(8'd0);
      end else if (kind < 15) begin
        noisy = 1'b1;
        text_q.delete();
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      // kind 15 leaves the number unterminated; the next start discards it
      send_text(noisy);
      if (kind < 11 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end

    // closing part without idling
    idling_on <= 1'b0;
    repeat (20) begin
      build_number();
      text_q.push_back(pick_stop());
      send_text(1'b0);
    end
    in_tvalid <= 1'b0;

    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
